// ===== src/tdpf_pkg.sv =====
// Shared types, codes and constants for the tail drop packet queue.
package tdpf_pkg;

  localparam int TDPF_QUEUE_DEPTH = 256;
  localparam int TDPF_ENTRY_W     = 32;

  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [1:0] KIND_FLUSH   = 2'd2;

  localparam logic [2:0] STATUS_ACCEPTED = 3'd0;
  localparam logic [2:0] STATUS_DROPPED  = 3'd1;
  localparam logic [2:0] STATUS_DEQUEUED = 3'd2;
  localparam logic [2:0] STATUS_EMPTY    = 3'd3;
  localparam logic [2:0] STATUS_FLUSHED  = 3'd4;

  localparam logic [1:0] CFG_LIMIT_MODE   = 2'd0;
  localparam logic [1:0] CFG_PACKET_LIMIT = 2'd1;
  localparam logic [1:0] CFG_BYTE_LIMIT   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] packet_handle;
    logic [15:0] packet_length;
  } tdpf_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [15:0] out_length;
    logic [8:0]  queued_packets;
    logic [31:0] queued_bytes;
  } tdpf_out_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DEQ  = 2'b10
  } tdpf_state_t;

endpackage

// ===== src/tdpf_store.sv =====
// Packet descriptor memory: one write port, one read port with registered data.
module tdpf_store
  import tdpf_pkg::*;
#(
  parameter int DEPTH = TDPF_QUEUE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [TDPF_ENTRY_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic [TDPF_ENTRY_W-1:0] rd_data
);

  logic [TDPF_ENTRY_W-1:0] mem [DEPTH];
  logic [TDPF_ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/tail_drop_packet_fifo_unit.sv =====
// Top level of the tail drop packet queue: request control, counters and descriptor memory.
//
//   channel   ports                              handshake
//   request   start, busy, in_data               taken when start high and busy low
//   result    out_valid, out_data                one-cycle strobe, cannot be held off
//   config    cfg_we, cfg_index, cfg_wdata       written on any edge with cfg_we high, outside reset
//
// Enqueue, flush and empty dequeue give their result in the cycle after the transaction.
// A dequeue with packets held passes through ST_DEQ: the descriptor memory read is
// registered, and busy stays high while the unit is in that state.
// Reset clears pointers and counters and sets the limits to their defaults; the memory keeps its contents.
// Results never stall: each one is shown for a single cycle.
module tail_drop_packet_fifo_unit
  import tdpf_pkg::*;
#(
  parameter int QUEUE_DEPTH = TDPF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  tdpf_in_t    in_data,
  output logic        out_valid,
  output tdpf_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tdpf_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   bytes_r, bytes_nxt;
  logic          out_valid_r, out_valid_nxt;
  tdpf_out_t     out_data_r, out_data_nxt;
  logic          limit_mode_r;
  logic [7:0]    packet_limit_r;
  logic [23:0]   byte_limit_r;

  logic                    mem_we;
  logic                    mem_re;
  logic [TDPF_ENTRY_W-1:0] mem_rdata;
  logic                    accept;
  logic                    admit;
  logic [32:0]             sum;
  logic [15:0]             rd_handle;
  logic [15:0]             rd_length;

  tdpf_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (tail_r),
    .wr_data ({in_data.packet_handle, in_data.packet_length}),
    .rd_en   (mem_re),
    .rd_addr (head_r),
    .rd_data (mem_rdata)
  );

  assign busy      = (state_r == ST_DEQ);
  assign accept    = start && (state_r == ST_IDLE);
  assign rd_handle = mem_rdata[31:16];
  assign rd_length = mem_rdata[15:0];
  assign sum       = {1'b0, bytes_r} + 33'(in_data.packet_length);

  always_comb begin
    if (count_r == CW'(QUEUE_DEPTH)) begin
      admit = 1'b0;
    end else if (limit_mode_r) begin
      admit = (bytes_r <= 32'(byte_limit_r));
    end else begin
      admit = (32'(count_r) <= 32'(packet_limit_r));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    bytes_nxt     = bytes_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.kind)
            KIND_ENQUEUE: begin
              out_valid_nxt = 1'b1;
              if (admit) begin
                mem_we    = 1'b1;
                tail_nxt  = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + AW'(1);
                count_nxt = count_r + CW'(1);
                bytes_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                out_data_nxt.status = STATUS_ACCEPTED;
              end else begin
                out_data_nxt.status = STATUS_DROPPED;
              end
              out_data_nxt.out_handle     = '0;
              out_data_nxt.out_length     = '0;
              out_data_nxt.queued_packets = 9'(count_nxt);
              out_data_nxt.queued_bytes   = bytes_nxt;
            end
            KIND_DEQUEUE: begin
              if (count_r == '0) begin
                out_valid_nxt               = 1'b1;
                out_data_nxt.status         = STATUS_EMPTY;
                out_data_nxt.out_handle     = '0;
                out_data_nxt.out_length     = '0;
                out_data_nxt.queued_packets = 9'(count_r);
                out_data_nxt.queued_bytes   = bytes_r;
              end else begin
                mem_re    = 1'b1;
                state_nxt = ST_DEQ;
              end
            end
            KIND_FLUSH: begin
              head_nxt                    = '0;
              tail_nxt                    = '0;
              count_nxt                   = '0;
              bytes_nxt                   = '0;
              out_valid_nxt               = 1'b1;
              out_data_nxt.status         = STATUS_FLUSHED;
              out_data_nxt.out_handle     = '0;
              out_data_nxt.out_length     = '0;
              out_data_nxt.queued_packets = '0;
              out_data_nxt.queued_bytes   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DEQ: begin
        head_nxt  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
        count_nxt = count_r - CW'(1);
        bytes_nxt = (bytes_r >= 32'(rd_length)) ? bytes_r - 32'(rd_length) : '0;
        out_valid_nxt               = 1'b1;
        out_data_nxt.status         = STATUS_DEQUEUED;
        out_data_nxt.out_handle     = rd_handle;
        out_data_nxt.out_length     = rd_length;
        out_data_nxt.queued_packets = 9'(count_nxt);
        out_data_nxt.queued_bytes   = bytes_nxt;
        state_nxt                   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_mode_r   <= 1'b0;
      packet_limit_r <= 8'd127;
      byte_limit_r   <= 24'd65535;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIMIT_MODE:   limit_mode_r   <= cfg_wdata[0];
        CFG_PACKET_LIMIT: packet_limit_r <= cfg_wdata[7:0];
        CFG_BYTE_LIMIT:   byte_limit_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the tail drop packet queue: predictor and scoreboard.
`timescale 1ns / 1ps

module testbench;
  import tdpf_pkg::*;

  localparam int         QUEUE_DEPTH    = TDPF_QUEUE_DEPTH;
  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam logic [1:0] CFG_NO_REGISTER = 2'd3;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         PHASE_COUNT    = 9;

  typedef struct {
    logic [15:0] handle;
    logic [15:0] length;
  } descriptor_t;

  typedef struct {
    tdpf_out_t       reply;
    longint unsigned issued;
  } reply_due_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  tdpf_in_t    in_data   = '0;
  logic        out_valid;
  tdpf_out_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  tdpf_in_t    requests_to_send[$];
  reply_due_t  replies_due[$];
  descriptor_t held_packets[$];
  logic [31:0] held_bytes       = '0;
  logic        limit_mode_cfg   = 1'b0;
  logic [7:0]  packet_limit_cfg = 8'd127;
  logic [23:0] byte_limit_cfg   = 24'd65535;

  longint unsigned cycle_no    = 0;
  int unsigned     failures    = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     burst_left  = 1;
  int unsigned     gap_left    = 0;

  tail_drop_packet_fifo_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  task automatic queue_model_apply(input tdpf_in_t req);
    tdpf_out_t   reply;
    bit          admit;
    logic [32:0] sum;
    descriptor_t desc;
    reply = '0;
    case (req.kind)
      KIND_ENQUEUE: begin
        if (held_packets.size() >= QUEUE_DEPTH) admit = 1'b0;
        else if (limit_mode_cfg) admit = (held_bytes <= {8'd0, byte_limit_cfg});
        else admit = (held_packets.size() <= packet_limit_cfg);
        if (admit) begin
          held_packets.push_back('{handle: req.packet_handle, length: req.packet_length});
          sum = {1'b0, held_bytes} + req.packet_length;
          held_bytes = sum[32] ? '1 : sum[31:0];
          reply.status = STATUS_ACCEPTED;
        end else begin
          reply.status = STATUS_DROPPED;
        end
      end
      KIND_DEQUEUE: begin
        if (held_packets.size() == 0) begin
          reply.status = STATUS_EMPTY;
        end else begin
          desc = held_packets.pop_front();
          held_bytes = (held_bytes >= desc.length) ? held_bytes - desc.length : '0;
          reply.status     = STATUS_DEQUEUED;
          reply.out_handle = desc.handle;
          reply.out_length = desc.length;
        end
      end
      KIND_FLUSH: begin
        held_packets.delete();
        held_bytes   = '0;
        reply.status = STATUS_FLUSHED;
      end
      default: return;
    endcase
    reply.queued_packets = 9'(held_packets.size());
    reply.queued_bytes   = held_bytes;
    replies_due.push_back('{reply: reply, issued: cycle_no});
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        queue_model_apply(in_data);
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (requests_to_send.size() == 0) begin
          start <= 1'b0;
        end else begin
          in_data <= requests_to_send.pop_front();
          start   <= 1'b1;
          if (burst_left > 1) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 6);
          end
        end
      end
    end
  end

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // monitor: results cannot be held off, so check every strobe
  always @(posedge clk) begin
    reply_due_t due;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0 || replies_due[0].issued == cycle_no) begin
        $error("result with no request outstanding: status %0d", out_data.status);
        failures++;
      end else begin
        due = replies_due.pop_front();
        check_field("status", due.reply.status, out_data.status);
        check_field("out_handle", due.reply.out_handle, out_data.out_handle);
        check_field("out_length", due.reply.out_length, out_data.out_length);
        check_field("queued_packets", due.reply.queued_packets, out_data.queued_packets);
        check_field("queued_bytes", due.reply.queued_bytes, out_data.queued_bytes);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1 || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void queue_request(input logic [1:0] kind, input logic [15:0] handle,
                                        input logic [15:0] length);
    tdpf_in_t req;
    req.kind          = kind;
    req.packet_handle = handle;
    req.packet_length = length;
    requests_to_send.push_back(req);
  endfunction

  function automatic bit queue_random_request(int enqueue_pct, int flush_pct);
    int          roll;
    logic [1:0]  kind;
    logic [15:0] length;
    roll = $urandom_range(0, 99);
    if (roll < 2) kind = KIND_UNUSED;
    else if (roll < 2 + flush_pct) kind = KIND_FLUSH;
    else if ($urandom_range(0, 99) < enqueue_pct) kind = KIND_ENQUEUE;
    else kind = KIND_DEQUEUE;
    case ($urandom_range(0, 9))
      0:       length = 16'h0000;
      1:       length = 16'hFFFF;
      2, 3, 4: length = 16'($urandom_range(0, 255));
      default: length = 16'($urandom);
    endcase
    queue_request(kind, 16'($urandom), length);
    return kind != KIND_UNUSED;
  endfunction

  task automatic wait_for_drain();
    do @(negedge clk);
    while (requests_to_send.size() != 0 || start || replies_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [23:0] value);
    logic [23:0] noise;
    noise = 24'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    case (idx)
      CFG_LIMIT_MODE: begin
        cfg_wdata      <= {noise[23:1], value[0]};
        limit_mode_cfg  = value[0];
      end
      CFG_PACKET_LIMIT: begin
        cfg_wdata        <= {noise[23:8], value[7:0]};
        packet_limit_cfg  = value[7:0];
      end
      CFG_BYTE_LIMIT: begin
        cfg_wdata      <= value;
        byte_limit_cfg  = value;
      end
      default: cfg_wdata <= noise;
    endcase
  endtask

  initial begin
    logic        mode;
    logic [7:0]  pkt_limit;
    logic [23:0] byte_limit;
    int          target;
    int          enqueue_pct;
    int          flush_pct;
    int          counted;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_request(KIND_DEQUEUE, 16'h0000, 16'h0000);
    queue_request(KIND_FLUSH,   16'hFFFF, 16'hFFFF);
    queue_request(KIND_ENQUEUE, 16'h0000, 16'h0000);
    queue_request(KIND_ENQUEUE, 16'hFFFF, 16'hFFFF);
    queue_request(KIND_ENQUEUE, 16'h5555, 16'hAAAA);
    queue_request(KIND_ENQUEUE, 16'hAAAA, 16'h5555);
    queue_request(KIND_UNUSED,  16'hFFFF, 16'hFFFF);
    repeat (4) queue_request(KIND_DEQUEUE, 16'hFFFF, 16'hFFFF);
    queue_request(KIND_ENQUEUE, 16'h1234, 16'd100);
    queue_request(KIND_ENQUEUE, 16'h4321, 16'd200);
    queue_request(KIND_FLUSH,   16'h0000, 16'h0000);
    queue_request(KIND_DEQUEUE, 16'h0000, 16'h0000);
    queue_request(KIND_ENQUEUE, 16'h0001, 16'h0001);
    queue_request(KIND_DEQUEUE, 16'h0000, 16'h0000);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_for_drain();
      pkt_limit  = 8'($urandom);
      byte_limit = 24'($urandom);
      case (p)
        0: begin mode = 1'b1; byte_limit = '0;    target = 80;  enqueue_pct = 60; end
        1: begin mode = 1'b0; pkt_limit  = 8'd255; target = 330; enqueue_pct = 95; end
        2: begin mode = 1'b0; pkt_limit  = 8'd0;   target = 110; enqueue_pct = 15; end
        3: begin mode = 1'b1; byte_limit = '1;     target = 180; enqueue_pct = 95; end
        4: begin
          mode = 1'b1; byte_limit = 24'($urandom_range(0, 300000)); target = 80;
          enqueue_pct = 60;
        end
        5: begin
          mode = 1'b0; pkt_limit = 8'($urandom_range(1, 20)); target = 80; enqueue_pct = 55;
        end
        6: begin mode = 1'b0; target = 80; enqueue_pct = 65; end
        7: begin mode = 1'b1; target = 80; enqueue_pct = 50; end
        default: begin mode = 1'($urandom); target = 80; enqueue_pct = 50; end
      endcase
      flush_pct = (enqueue_pct > 90 || p < 3) ? 0 : 3;
      if (p == 0) write_register(CFG_NO_REGISTER, 24'($urandom));
      write_register(CFG_LIMIT_MODE, {23'd0, mode});
      write_register(CFG_PACKET_LIMIT, {16'd0, pkt_limit});
      write_register(CFG_BYTE_LIMIT, byte_limit);
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      counted = 0;
      while (counted < target) counted += queue_random_request(enqueue_pct, flush_pct);
    end

    wait_for_drain();
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
